/* hw/rtl/vass_pkg.sv */
// Shared constants and types for the view angle slice selector.
`default_nettype none
package vass_pkg;

    localparam int DEF_MAX_SLICES      = 256;
    localparam int DEF_COORD_FRAC_BITS = 16;

    // Square root cells: one result bit per cell, 64 bit radicand.
    localparam int SQRT_STEPS = 32;
    // Divide cells: quotient bits 24 down to 0.
    localparam int DIV_STEPS  = 25;

    localparam logic [22:0] SCALE_Q24   = 23'd4193885;
    localparam int          QUARTER_Q24 = 4194304;
    localparam int          ONE_Q24     = 16777216;

    // Per-beat data that rides along the square root and divide cells.
    typedef struct packed {
        logic [31:0]        mx;
        logic [31:0]        mz;
        logic               neg_x;
        logic               neg_z;
        logic signed [15:0] ref_x;
        logic signed [15:0] ref_z;
        logic signed [15:0] ang_x;
        logic signed [15:0] ang_z;
        logic [8:0]         count;
        logic               bad;
    } side_t;

endpackage
`default_nettype wire

/* hw/rtl/vass_sqrt_cell.sv */
// One step of the bit-pair integer square root chain.
`default_nettype none
module vass_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire                  valid_in,
    input  wire [63:0]           v_in,
    input  wire [63:0]           r_in,
    input  vass_pkg::side_t      side_in,
    output logic                 valid_out,
    output logic [63:0]          v_out,
    output logic [63:0]          r_out,
    output vass_pkg::side_t      side_out
);
    import vass_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic        valid_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    side_t       side_reg;
    logic [63:0] trial;
    logic [63:0] v_next;
    logic [63:0] r_next;

    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign v_out     = v_reg;
    assign r_out     = r_reg;
    assign side_out  = side_reg;

endmodule
`default_nettype wire

/* hw/rtl/vass_div_cell.sv */
// One restoring-division step for both unit-vector components.
`default_nettype none
module vass_div_cell #(
    parameter bit SHIFT = 1'b1
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire                  valid_in,
    input  wire [32:0]           rem_x_in,
    input  wire [32:0]           rem_z_in,
    input  wire [24:0]           q_x_in,
    input  wire [24:0]           q_z_in,
    input  wire [31:0]           len_in,
    input  vass_pkg::side_t      side_in,
    output logic                 valid_out,
    output logic [32:0]          rem_x_out,
    output logic [32:0]          rem_z_out,
    output logic [24:0]          q_x_out,
    output logic [24:0]          q_z_out,
    output logic [31:0]          len_out,
    output vass_pkg::side_t      side_out
);
    import vass_pkg::*;

    logic        valid_reg;
    logic [32:0] rem_x_reg;
    logic [32:0] rem_z_reg;
    logic [24:0] q_x_reg;
    logic [24:0] q_z_reg;
    logic [31:0] len_reg;
    side_t       side_reg;
    logic [32:0] tx;
    logic [32:0] tz;
    logic [32:0] dv;
    logic        bx;
    logic        bz;

    always_comb
    begin
        dv = {1'b0, len_in};
        tx = SHIFT ? {rem_x_in[31:0], 1'b0} : rem_x_in;
        tz = SHIFT ? {rem_z_in[31:0], 1'b0} : rem_z_in;
        bx = (tx >= dv);
        bz = (tz >= dv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_reg <= bx ? (tx - dv) : tx;
            rem_z_reg <= bz ? (tz - dv) : tz;
            q_x_reg   <= {q_x_in[23:0], bx};
            q_z_reg   <= {q_z_in[23:0], bz};
            len_reg   <= len_in;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_z_out = rem_z_reg;
    assign q_x_out   = q_x_reg;
    assign q_z_out   = q_z_reg;
    assign len_out   = len_reg;
    assign side_out  = side_reg;

endmodule
`default_nettype wire

/* hw/rtl/view_angle_slice_select.sv */
// Top level of the view angle slice selector pipeline.
//
// Each input beat carries an object origin, a camera position (X and Z),
// a reference axis, an angle axis, a slice count and a centre slice.
// Each beat produces exactly one result beat: the selected slice index and
// a flag that says whether a selection was made. Bad counts, a bad centre,
// a zero axis or a vanishing horizontal distance give index zero and a
// cleared flag.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. A new beat can enter on every cycle while in_stall is low.
// The chain has four front stages (difference, range halving,
// squaring, sum), 32 square root cells, 25 divide cells and six back
// stages (sign, axis products, dot products, scale split, angle, slice
// output).
// The whole chain advances together. When the receiver stalls while a
// result waits in the output register, the chain holds and in_stall rises
// in the same cycle; empty slots in the chain still count as stages.
// Reset clears every valid bit in the chain; payload registers are not
// reset and no result is shown until a beat has passed through.
`default_nettype none
module view_angle_slice_select #(
    parameter int MAX_SLICES      = vass_pkg::DEF_MAX_SLICES,
    parameter int COORD_FRAC_BITS = vass_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire signed [31:0]  origin_x,
    input  wire signed [31:0]  origin_z,
    input  wire signed [31:0]  camera_x,
    input  wire signed [31:0]  camera_z,
    input  wire signed [15:0]  ref_axis_x,
    input  wire signed [15:0]  ref_axis_z,
    input  wire signed [15:0]  angle_axis_x,
    input  wire signed [15:0]  angle_axis_z,
    input  wire [8:0]          slice_count,
    input  wire [8:0]          centre_slice,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [7:0]         slice_index,
    output logic               valid_res
);
    import vass_pkg::*;

    // Squared distances at or below this bound count as zero distance.
    localparam logic [63:0] DIST_SQ_MIN =
        (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd1000000000000;
    localparam logic [9:0] MAX_CNT = 10'(MAX_SLICES);

    logic en;

    // The chain moves unless a finished result is being held back.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Stage 1: differences and magnitudes, early input checks.
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic               bad_in;
    logic               s1_valid_reg;
    logic [32:0]        s1_mx_reg;
    logic [32:0]        s1_mz_reg;
    side_t              s1_side_reg;
    side_t              s1_side_next;

    always_comb
    begin
        dx = {camera_x[31], camera_x} - {origin_x[31], origin_x};
        dz = {camera_z[31], camera_z} - {origin_z[31], origin_z};
        bad_in = (slice_count == 9'd0) || ({1'b0, slice_count} > MAX_CNT) ||
                 (centre_slice >= slice_count) ||
                 ((ref_axis_x == 16'sd0) && (ref_axis_z == 16'sd0)) ||
                 ((angle_axis_x == 16'sd0) && (angle_axis_z == 16'sd0));
        s1_side_next.mx    = 32'd0;
        s1_side_next.mz    = 32'd0;
        s1_side_next.neg_x = dx[32];
        s1_side_next.neg_z = dz[32];
        s1_side_next.ref_x = ref_axis_x;
        s1_side_next.ref_z = ref_axis_z;
        s1_side_next.ang_x = angle_axis_x;
        s1_side_next.ang_z = angle_axis_z;
        s1_side_next.count = slice_count;
        s1_side_next.bad   = bad_in;
    end

    // Stage 2: halve both magnitudes if either reaches 2^31.
    logic        big;
    logic        s2_valid_reg;
    logic        s2_big_reg;
    side_t       s2_side_reg;
    side_t       s2_side_next;

    always_comb
    begin
        big = s1_mx_reg[32] | s1_mx_reg[31] | s1_mz_reg[32] | s1_mz_reg[31];
        s2_side_next    = s1_side_reg;
        s2_side_next.mx = big ? s1_mx_reg[32:1] : s1_mx_reg[31:0];
        s2_side_next.mz = big ? s1_mz_reg[32:1] : s1_mz_reg[31:0];
    end

    // Stage 3: squares. Stage 4: sum and zero-distance check.
    logic        s3_valid_reg;
    logic        s3_big_reg;
    logic [63:0] s3_sqx_reg;
    logic [63:0] s3_sqz_reg;
    side_t       s3_side_reg;
    logic [63:0] sum_sq;
    logic        s4_valid_reg;
    logic [63:0] s4_sum_reg;
    side_t       s4_side_reg;
    side_t       s4_side_next;

    always_comb
    begin
        sum_sq = s3_sqx_reg + s3_sqz_reg;
        s4_side_next     = s3_side_reg;
        s4_side_next.bad = s3_side_reg.bad || (!s3_big_reg && (sum_sq <= DIST_SQ_MIN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mx_reg   <= dx[32] ? 33'(-dx) : 33'(dx);
            s1_mz_reg   <= dz[32] ? 33'(-dz) : 33'(dz);
            s1_side_reg <= s1_side_next;
            s2_big_reg  <= big;
            s2_side_reg <= s2_side_next;
            s3_big_reg  <= s2_big_reg;
            s3_sqx_reg  <= {32'd0, s2_side_reg.mx} * {32'd0, s2_side_reg.mx};
            s3_sqz_reg  <= {32'd0, s2_side_reg.mz} * {32'd0, s2_side_reg.mz};
            s3_side_reg <= s2_side_reg;
            s4_sum_reg  <= sum_sq;
            s4_side_reg <= s4_side_next;
        end
    end

    // Square root chain.
    logic        sq_valid [SQRT_STEPS+1];
    logic [63:0] sq_v     [SQRT_STEPS+1];
    logic [63:0] sq_r     [SQRT_STEPS+1];
    side_t       sq_side  [SQRT_STEPS+1];

    assign sq_valid[0] = s4_valid_reg;
    assign sq_v[0]     = s4_sum_reg;
    assign sq_r[0]     = 64'd0;
    assign sq_side[0]  = s4_side_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        vass_sqrt_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[i]),
            .v_in      (sq_v[i]),
            .r_in      (sq_r[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_valid[i+1]),
            .v_out     (sq_v[i+1]),
            .r_out     (sq_r[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // Divide chain: unit components = magnitude * 2^24 / length.
    logic        dv_valid [DIV_STEPS+1];
    logic [32:0] dv_rx    [DIV_STEPS+1];
    logic [32:0] dv_rz    [DIV_STEPS+1];
    logic [24:0] dv_qx    [DIV_STEPS+1];
    logic [24:0] dv_qz    [DIV_STEPS+1];
    logic [31:0] dv_len   [DIV_STEPS+1];
    side_t       dv_side  [DIV_STEPS+1];
    side_t       dv_side0;

    always_comb
    begin
        dv_side0     = sq_side[SQRT_STEPS];
        dv_side0.bad = sq_side[SQRT_STEPS].bad || (sq_r[SQRT_STEPS] == 64'd0);
    end

    assign dv_valid[0] = sq_valid[SQRT_STEPS];
    assign dv_rx[0]    = {1'b0, sq_side[SQRT_STEPS].mx};
    assign dv_rz[0]    = {1'b0, sq_side[SQRT_STEPS].mz};
    assign dv_qx[0]    = 25'd0;
    assign dv_qz[0]    = 25'd0;
    assign dv_len[0]   = sq_r[SQRT_STEPS][31:0];
    assign dv_side[0]  = dv_side0;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        vass_div_cell #(.SHIFT(k != 0)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[k]),
            .rem_x_in  (dv_rx[k]),
            .rem_z_in  (dv_rz[k]),
            .q_x_in    (dv_qx[k]),
            .q_z_in    (dv_qz[k]),
            .len_in    (dv_len[k]),
            .side_in   (dv_side[k]),
            .valid_out (dv_valid[k+1]),
            .rem_x_out (dv_rx[k+1]),
            .rem_z_out (dv_rz[k+1]),
            .q_x_out   (dv_qx[k+1]),
            .q_z_out   (dv_qz[k+1]),
            .len_out   (dv_len[k+1]),
            .side_out  (dv_side[k+1])
        );
    end

    // Back stages.
    side_t              dvo;
    logic [25:0]        qx_ext;
    logic [25:0]        qz_ext;

    assign dvo    = dv_side[DIV_STEPS];
    assign qx_ext = {1'b0, dv_qx[DIV_STEPS]};
    assign qz_ext = {1'b0, dv_qz[DIV_STEPS]};

    // E1: signed unit components.
    logic               e1_valid_reg;
    logic signed [25:0] e1_ux_reg;
    logic signed [25:0] e1_uz_reg;
    side_t              e1_side_reg;
    // E2: four axis products.
    logic               e2_valid_reg;
    logic signed [41:0] e2_pax_reg;
    logic signed [41:0] e2_paz_reg;
    logic signed [41:0] e2_prx_reg;
    logic signed [41:0] e2_prz_reg;
    logic [8:0]         e2_count_reg;
    logic               e2_bad_reg;
    // E3: dot products.
    logic               e3_valid_reg;
    logic signed [42:0] e3_dota_reg;
    logic               e3_rneg_reg;
    logic [8:0]         e3_count_reg;
    logic               e3_bad_reg;
    logic signed [42:0] dot_r;
    // E4: scale split into two partial products.
    logic               e4_valid_reg;
    logic signed [45:0] e4_phi_reg;
    logic [43:0]        e4_plo_reg;
    logic               e4_rneg_reg;
    logic [8:0]         e4_count_reg;
    logic               e4_bad_reg;
    logic signed [21:0] dota_hi;
    logic [20:0]        dota_lo;
    // E5: angle with mirror and clamp.
    logic               e5_valid_reg;
    logic [24:0]        e5_angle_reg;
    logic [8:0]         e5_count_reg;
    logic               e5_bad_reg;
    logic signed [67:0] term;
    logic signed [29:0] fl;
    logic signed [31:0] ang_a;
    logic signed [31:0] ang_m;
    logic [24:0]        ang_c;
    // E6: slice index into the output register.
    logic [33:0]        slice_prod;
    logic [9:0]         idx_raw;
    logic [9:0]         idx_sat;
    logic               out_valid_reg;
    logic [7:0]         slice_index_reg;
    logic               valid_res_reg;

    always_comb
    begin
        dot_r   = 43'(e2_prx_reg) + 43'(e2_prz_reg);
        dota_hi = e3_dota_reg[42:21];
        dota_lo = e3_dota_reg[20:0];
        term    = (68'(e4_phi_reg) <<< 21) + $signed({24'd0, e4_plo_reg});
        fl      = term[67:38];
        ang_a   = 32'(QUARTER_Q24) - 32'(fl);
        ang_m   = e4_rneg_reg ? (32'(ONE_Q24) - ang_a) : ang_a;
        if (ang_m < 32'sd0)
        begin
            ang_c = 25'd0;
        end
        else if (ang_m > 32'(ONE_Q24))
        begin
            ang_c = 25'(ONE_Q24);
        end
        else
        begin
            ang_c = ang_m[24:0];
        end
        slice_prod = {9'd0, e5_angle_reg} * {25'd0, e5_count_reg};
        idx_raw    = slice_prod[33:24];
        idx_sat    = (idx_raw >= {1'b0, e5_count_reg}) ?
                     ({1'b0, e5_count_reg} - 10'd1) : idx_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            e4_valid_reg  <= 1'b0;
            e5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_valid_reg  <= dv_valid[DIV_STEPS];
            e2_valid_reg  <= e1_valid_reg;
            e3_valid_reg  <= e2_valid_reg;
            e4_valid_reg  <= e3_valid_reg;
            e5_valid_reg  <= e4_valid_reg;
            out_valid_reg <= e5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_ux_reg    <= dvo.neg_x ? $signed(-qx_ext) : $signed(qx_ext);
            e1_uz_reg    <= dvo.neg_z ? $signed(-qz_ext) : $signed(qz_ext);
            e1_side_reg  <= dvo;

            e2_pax_reg   <= 42'(e1_ux_reg) * 42'(e1_side_reg.ang_x);
            e2_paz_reg   <= 42'(e1_uz_reg) * 42'(e1_side_reg.ang_z);
            e2_prx_reg   <= 42'(e1_ux_reg) * 42'(e1_side_reg.ref_x);
            e2_prz_reg   <= 42'(e1_uz_reg) * 42'(e1_side_reg.ref_z);
            e2_count_reg <= e1_side_reg.count;
            e2_bad_reg   <= e1_side_reg.bad;

            e3_dota_reg  <= 43'(e2_pax_reg) + 43'(e2_paz_reg);
            e3_rneg_reg  <= dot_r[42];
            e3_count_reg <= e2_count_reg;
            e3_bad_reg   <= e2_bad_reg;

            e4_phi_reg   <= 46'(dota_hi) * $signed({23'd0, SCALE_Q24});
            e4_plo_reg   <= {23'd0, dota_lo} * {21'd0, SCALE_Q24};
            e4_rneg_reg  <= e3_rneg_reg;
            e4_count_reg <= e3_count_reg;
            e4_bad_reg   <= e3_bad_reg;

            e5_angle_reg <= ang_c;
            e5_count_reg <= e4_count_reg;
            e5_bad_reg   <= e4_bad_reg;

            slice_index_reg <= e5_bad_reg ? 8'd0 : idx_sat[7:0];
            valid_res_reg   <= !e5_bad_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slice_index = slice_index_reg;
    assign valid_res   = valid_res_reg;

endmodule
`default_nettype wire

/* hw/rtl/vass_checker.sv */
// Port-level checks for the view angle slice selector, bound to the top level.
`default_nettype none
module vass_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_stall,
    input wire       out_valid,
    input wire       out_stall,
    input wire [7:0] slice_index,
    input wire       valid_res
);

    // An invalid result always reports slice zero.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (slice_index == 8'd0))
        else $error("invalid result with nonzero slice index");

    // The input side only stalls while a result is held back at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // With the output free, the input side never stalls.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // A held result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(slice_index) && $stable(valid_res)))
        else $error("stalled result changed");

endmodule

bind view_angle_slice_select vass_checker u_vass_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slice_index (slice_index),
    .valid_res   (valid_res)
);
`default_nettype wire
